[rtl/bpc_pkg.sv]
// Shared types and constants of the barometer compensation core.
package bpc_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int DT_W      = 25;
  localparam int TEMP_W    = 21;
  localparam int TERM_W    = 40;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 21'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -21'sd1500;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] off_tc;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_sens;
  } coef_t;

  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [DT_W-1:0] dt;
  } entry_t;

endpackage

[rtl/baro_pressure_temp_compensation_core.sv]
// Barometer pressure and temperature compensation core, top level.
//
// Channels: in_* carries one raw pressure / raw temperature pair per item,
// out_* returns the compensated pressure (Pa) and temperature (0.01 C),
// cfg_* writes the six 16-bit coefficients by register index; writes to an
// index above five are dropped. cfg_ready is always high; write the
// coefficients only while no item is in flight.
// Path: an accepted item passes through the input stage, then the queue, then
// the eight arithmetic stages, the last of which is the output register.
// Throughput: one item per cycle unless stalled, set by the fully pipelined multiply chain.
// Stall: a low out_tready with out_tvalid high freezes the arithmetic pipeline;
// the input stage and the queue keep taking items until the queue fills, then
// in_tready drops. Reset clears the coefficients to zero and empties every stage.
module baro_pressure_temp_compensation_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]        in_tdata,   // raw_pressure, raw_temperature
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]       out_tdata,  // pressure_pa, temp_centi_c
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]           cfg_data
);
  import bpc_pkg::*;

  coef_t  coef_r, coef_nxt;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENS:      coef_nxt.sens      = cfg_data;
        REG_OFF:       coef_nxt.off       = cfg_data;
        REG_SENS_TC:   coef_nxt.sens_tc   = cfg_data;
        REG_OFF_TC:    coef_nxt.off_tc    = cfg_data;
        REG_REF_TEMP:  coef_nxt.ref_temp  = cfg_data;
        REG_TEMP_SENS: coef_nxt.temp_sens = cfg_data;
        default:       coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  bpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .coef       (coef_r),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  bpc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/bpc_front.sv]
// Input stage: take an item, form dT and hand it to the queue.
module bpc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]       in_tdata,  // raw_pressure, raw_temperature
  input  bpc_pkg::coef_t                      coef,
  output logic                                push_valid,
  output bpc_pkg::entry_t                     push_data,
  input  logic                                push_ready
);
  import bpc_pkg::*;

  logic   vld_r, vld_nxt;
  entry_t ent_r, ent_nxt;

  assign in_tready  = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_data  = ent_r;

  always_comb begin
    vld_nxt    = in_tready ? in_tvalid : vld_r;
    ent_nxt.d1 = in_tdata[RAW_W-1:0];
    ent_nxt.dt = $signed({1'b0, in_tdata[2*RAW_W-1:RAW_W]})
               - $signed({1'b0, coef.ref_temp, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

[rtl/bpc_fifo.sv]
// Short queue between the input stage and the arithmetic pipeline.
module bpc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  bpc_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bpc_pkg::entry_t pop_data
);
  import bpc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

[rtl/bpc_back.sv]
// Eight-stage compensation pipeline with the output register as last stage.
module bpc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpc_pkg::coef_t                 coef,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  bpc_pkg::entry_t                pop_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0] out_tdata  // pressure_pa, temp_centi_c
);
  import bpc_pkg::*;

  logic [7:0] vld_r, vld_nxt;
  logic       en;

  // stage 1: products of dT
  logic [RAW_W-1:0]          d1_1_r;
  logic signed [41:0]        poff_1_r, psens_1_r, ptemp_1_r;
  logic signed [49:0]        pdtsq_1_r;
  logic signed [DT_W-1:0]    dt_w;
  logic signed [41:0]        poff_nxt, psens_nxt, ptemp_nxt;
  logic signed [49:0]        pdtsq_nxt;

  // stage 2: first-order terms
  logic [RAW_W-1:0]          d1_2_r;
  logic signed [TERM_W-1:0]  off_2_r, sens_2_r, off_2_nxt, sens_2_nxt;
  logic signed [TEMP_W-1:0]  temp_2_r, temp_2_nxt;
  logic [18:0]               tcorr_2_r, tcorr_2_nxt;

  // stage 3: squares and range flags
  logic [RAW_W-1:0]          d1_3_r;
  logic signed [TERM_W-1:0]  off_3_r, sens_3_r;
  logic signed [TEMP_W-1:0]  temp_3_r;
  logic [18:0]               tcorr_3_r;
  logic [35:0]               dsq_3_r, rsq_3_r;
  logic                      low_3_r, vlow_3_r;
  logic signed [TEMP_W-1:0]  dd, ee;
  logic signed [41:0]        dsq_full, rsq_full;

  // stage 4: scaled corrections
  logic [RAW_W-1:0]          d1_4_r;
  logic signed [TERM_W-1:0]  off_4_r, sens_4_r;
  logic signed [TEMP_W-1:0]  temp_4_r, temp_4_nxt;
  logic [38:0]               q5_4_r, r7_4_r, r11h_4_r, q5_nxt, r7_nxt;
  logic [39:0]               r11_full;
  logic                      low_4_r, vlow_4_r;

  // stage 5: corrected offset and sensitivity
  logic [RAW_W-1:0]          d1_5_r;
  logic signed [TERM_W-1:0]  off_5_r, sens_5_r, off_5_nxt, sens_5_nxt;
  logic signed [TERM_W-1:0]  qo, qs, ro, rs;
  logic signed [TEMP_W-1:0]  temp_5_r;

  // stage 6: partial products of D1 * SENS
  logic [43:0]               pl_6_r, pl_nxt;
  logic signed [44:0]        ph_6_r, ph_nxt;
  logic signed [TERM_W-1:0]  off_6_r;
  logic signed [TEMP_W-1:0]  temp_6_r;

  // stage 7: full product
  logic signed [65:0]        prod_7_r, prod_nxt, phx;
  logic signed [TERM_W-1:0]  off_7_r;
  logic signed [TEMP_W-1:0]  temp_7_r;

  // stage 8: output register
  logic signed [46:0]        pshift, pdiff;
  logic [31:0]               press_8_r, temp_8_r, press_nxt;

  assign en         = !vld_r[7] || out_tready;
  assign pop_ready  = en;
  assign out_tvalid = vld_r[7];
  assign out_tdata  = {temp_8_r, press_8_r};

  always_comb begin
    vld_nxt = en ? {vld_r[6:0], pop_valid} : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    dt_w      = pop_data.dt;
    poff_nxt  = $signed({1'b0, coef.off_tc}) * dt_w;
    psens_nxt = $signed({1'b0, coef.sens_tc}) * dt_w;
    ptemp_nxt = $signed({1'b0, coef.temp_sens}) * dt_w;
    pdtsq_nxt = dt_w * dt_w;
  end

  always_comb begin
    off_2_nxt   = $signed({8'd0, coef.off, 16'd0}) + TERM_W'(poff_1_r >>> 7);
    sens_2_nxt  = $signed({9'd0, coef.sens, 15'd0}) + TERM_W'(psens_1_r >>> 8);
    temp_2_nxt  = TEMP_W'(ptemp_1_r >>> 23) + TEMP_REF;
    tcorr_2_nxt = 19'(pdtsq_1_r >>> 31);
  end

  always_comb begin
    dd       = temp_2_r - TEMP_REF;
    ee       = temp_2_r - TEMP_VLOW;
    dsq_full = dd * dd;
    rsq_full = ee * ee;
  end

  always_comb begin
    q5_nxt     = {1'b0, dsq_3_r, 2'b00} + {3'b000, dsq_3_r};
    r7_nxt     = {rsq_3_r, 3'b000} - {3'b000, rsq_3_r};
    r11_full   = {1'b0, rsq_3_r, 3'b000} + {3'b000, rsq_3_r, 1'b0} + {4'b0000, rsq_3_r};
    temp_4_nxt = low_3_r ? (temp_3_r - $signed({2'b00, tcorr_3_r})) : temp_3_r;
  end

  always_comb begin
    qo         = low_4_r  ? $signed({2'b00, q5_4_r[38:1]}) : '0;
    qs         = low_4_r  ? $signed({3'b000, q5_4_r[38:2]}) : '0;
    ro         = vlow_4_r ? $signed({1'b0, r7_4_r}) : '0;
    rs         = vlow_4_r ? $signed({1'b0, r11h_4_r}) : '0;
    off_5_nxt  = off_4_r - qo - ro;
    sens_5_nxt = sens_4_r - qs - rs;
  end

  always_comb begin
    pl_nxt = d1_5_r * sens_5_r[19:0];
    ph_nxt = $signed({1'b0, d1_5_r}) * $signed(sens_5_r[39:20]);
  end

  always_comb begin
    phx      = ph_6_r;
    prod_nxt = (phx <<< 20) + $signed({22'd0, pl_6_r});
  end

  always_comb begin
    pshift    = 47'(prod_7_r >>> 21);
    pdiff     = pshift - 47'(off_7_r);
    press_nxt = 32'(pdiff >>> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_1_r    <= pop_data.d1;
      poff_1_r  <= poff_nxt;
      psens_1_r <= psens_nxt;
      ptemp_1_r <= ptemp_nxt;
      pdtsq_1_r <= pdtsq_nxt;

      d1_2_r    <= d1_1_r;
      off_2_r   <= off_2_nxt;
      sens_2_r  <= sens_2_nxt;
      temp_2_r  <= temp_2_nxt;
      tcorr_2_r <= tcorr_2_nxt;

      d1_3_r    <= d1_2_r;
      off_3_r   <= off_2_r;
      sens_3_r  <= sens_2_r;
      temp_3_r  <= temp_2_r;
      tcorr_3_r <= tcorr_2_r;
      dsq_3_r   <= dsq_full[35:0];
      rsq_3_r   <= rsq_full[35:0];
      low_3_r   <= (temp_2_r < TEMP_REF);
      vlow_3_r  <= (temp_2_r < TEMP_VLOW);

      d1_4_r    <= d1_3_r;
      off_4_r   <= off_3_r;
      sens_4_r  <= sens_3_r;
      temp_4_r  <= temp_4_nxt;
      q5_4_r    <= q5_nxt;
      r7_4_r    <= r7_nxt;
      r11h_4_r  <= r11_full[39:1];
      low_4_r   <= low_3_r;
      vlow_4_r  <= vlow_3_r;

      d1_5_r    <= d1_4_r;
      off_5_r   <= off_5_nxt;
      sens_5_r  <= sens_5_nxt;
      temp_5_r  <= temp_4_r;

      pl_6_r    <= pl_nxt;
      ph_6_r    <= ph_nxt;
      off_6_r   <= off_5_r;
      temp_6_r  <= temp_5_r;

      prod_7_r  <= prod_nxt;
      off_7_r   <= off_6_r;
      temp_7_r  <= temp_6_r;

      press_8_r <= press_nxt;
      temp_8_r  <= 32'(temp_7_r);
    end
  end

endmodule

[rtl/bpc_checker.sv]
// Port-level checks of the compensation core, bound to the top level.
module bpc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [bpc_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import bpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:50] == 14'h0000 || out_tdata[63:50] == 14'h3fff))
    else $error("temperature outside reachable range");

  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:28] == 4'h0 || out_tdata[31:28] == 4'hf))
    else $error("pressure outside reachable range");

endmodule

bind baro_pressure_temp_compensation_core bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
